/* rtl/bdqs_pkg.sv */
// Package: shared constants, codes and types of the bounded deque with search.
`timescale 1ns / 1ps

package bdqs_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OpPushBack   = 2'd0,
    OpPushFront  = 2'd1,
    OpSearch     = 2'd2,
    OpRemoveFront = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusDone  = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CellHold       = 2'd0,
    CellShiftLeft  = 2'd1,
    CellShiftRight = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e         cmd;
    logic              load_en;
    logic [IdxW-1:0]   load_idx;
  } chain_ctrl_t;

endpackage

/* rtl/bdqs_cell.sv */
// Module: one storage cell of the entry chain.
`timescale 1ns / 1ps

module bdqs_cell (
  input  logic                            clk_i,
  input  bdqs_pkg::cell_cmd_e             cmd_i,
  input  logic                            load_i,
  input  logic signed [bdqs_pkg::DataW-1:0] value_i,
  input  logic signed [bdqs_pkg::DataW-1:0] left_i,
  input  logic signed [bdqs_pkg::DataW-1:0] right_i,
  output logic signed [bdqs_pkg::DataW-1:0] data_o
);

  logic signed [bdqs_pkg::DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = value_i;
    end else begin
      case (cmd_i)
        bdqs_pkg::CellShiftLeft:  data_d = right_i;
        bdqs_pkg::CellShiftRight: data_d = left_i;
        default:                  data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/bdqs_ctrl.sv */
// Module: request sequencer, entry counter and search compare of the deque.
`timescale 1ns / 1ps

module bdqs_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  bdqs_pkg::op_e                     opcode_i,
  input  logic signed [bdqs_pkg::DataW-1:0] value_i,
  input  logic signed [bdqs_pkg::DataW-1:0] head_i,
  output logic                              busy_o,
  output bdqs_pkg::chain_ctrl_t             chain_o,
  output logic                              done_o,
  output logic                              found_o,
  output bdqs_pkg::status_e                 status_o,
  output logic [bdqs_pkg::CntW-1:0]         held_count_o
);

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StSearch = 2'b10
  } state_e;

  localparam logic [bdqs_pkg::IdxW-1:0] LastStep = bdqs_pkg::IdxW'(bdqs_pkg::Depth - 1);
  localparam logic [bdqs_pkg::CntW-1:0] FullCnt  = bdqs_pkg::CntW'(bdqs_pkg::Depth);

  state_e                            state_q, state_d;
  logic [bdqs_pkg::CntW-1:0]         count_q, count_d;
  logic [bdqs_pkg::IdxW-1:0]         step_q, step_d;
  logic signed [bdqs_pkg::DataW-1:0] key_q, key_d;
  logic                              hit_q, hit_d;
  logic                              done_q, done_d;
  logic                              found_q, found_d;
  bdqs_pkg::status_e                 status_q, status_d;

  logic accept;
  logic full;
  logic empty;
  logic match;

  assign accept = start_i && (state_q == StIdle);
  assign full   = (count_q == FullCnt);
  assign empty  = (count_q == '0);
  assign match  = (head_i == key_q) && ({1'b0, step_q} < count_q);

  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    step_d           = step_q;
    key_d            = key_q;
    hit_d            = hit_q;
    done_d           = 1'b0;
    found_d          = found_q;
    status_d         = status_q;
    chain_o.cmd      = bdqs_pkg::CellHold;
    chain_o.load_en  = 1'b0;
    chain_o.load_idx = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          done_d   = 1'b1;
          found_d  = 1'b0;
          status_d = bdqs_pkg::StatusDone;
          unique case (opcode_i)
            bdqs_pkg::OpPushBack: begin
              if (full) begin
                status_d = bdqs_pkg::StatusFull;
              end else begin
                chain_o.load_en  = 1'b1;
                chain_o.load_idx = count_q[bdqs_pkg::IdxW-1:0];
                count_d          = count_q + 1'b1;
              end
            end
            bdqs_pkg::OpPushFront: begin
              if (full) begin
                status_d = bdqs_pkg::StatusFull;
              end else begin
                chain_o.cmd      = bdqs_pkg::CellShiftRight;
                chain_o.load_en  = 1'b1;
                chain_o.load_idx = '0;
                count_d          = count_q + 1'b1;
              end
            end
            bdqs_pkg::OpSearch: begin
              done_d  = 1'b0;
              key_d   = value_i;
              hit_d   = 1'b0;
              step_d  = '0;
              state_d = StSearch;
            end
            default: begin
              if (empty) begin
                status_d = bdqs_pkg::StatusEmpty;
              end else begin
                chain_o.cmd = bdqs_pkg::CellShiftLeft;
                count_d     = count_q - 1'b1;
              end
            end
          endcase
        end
      end
      StSearch: begin
        chain_o.cmd = bdqs_pkg::CellShiftLeft;
        hit_d       = hit_q || match;
        step_d      = step_q + 1'b1;
        if (step_q == LastStep) begin
          done_d   = 1'b1;
          found_d  = hit_q || match;
          status_d = bdqs_pkg::StatusDone;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    key_q    <= key_d;
    hit_q    <= hit_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign busy_o       = (state_q != StIdle);
  assign done_o       = done_q;
  assign found_o      = found_q;
  assign status_o     = status_q;
  assign held_count_o = count_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count exceeds depth");

  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) && (step_q == LastStep) |=> done_q && (state_q == StIdle))
    else $error("search did not end with a result");

  a_found_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && found_q |-> $past(state_q == StSearch))
    else $error("found flagged outside a search");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q == bdqs_pkg::StatusFull) |-> (count_q == FullCnt))
    else $error("push refused while not full");
`endif

endmodule

/* rtl/bounded_deque_with_search_core.sv */
// Module: top level of the bounded deque with linear search, built as a chain of cells.
`timescale 1ns / 1ps

// Channel   Direction  Transfer when        Payload
// request   in         start_i && !busy_o   opcode_i, value_i
// result    out        done_o (one cycle)   found_o, status_o, held_count_o
//
// Push back, push front and remove front: the result strobes in the cycle after the
// transfer and busy_o stays low, so a new request may follow at once.
// A search rotates the whole chain once past the compare at cell 0, busy_o high
// throughout; the result strobes in the cycle after the last compare.
// Reset clears the count and the sequencer; cell contents are left undefined.
// The receiver cannot stall: each result is shown for exactly one cycle.

module bounded_deque_with_search_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [bdqs_pkg::DataW-1:0] value_i,
  output logic                              done_o,
  output logic                              found_o,
  output logic [1:0]                        status_o,
  output logic [bdqs_pkg::CntW-1:0]         held_count_o
);

  // Cell i holds the entry i places behind the front; cell 0 is the front.
  logic signed [bdqs_pkg::DataW-1:0] cell_data [bdqs_pkg::Depth];
  bdqs_pkg::chain_ctrl_t             chain;
  bdqs_pkg::status_e                 status;

  bdqs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .opcode_i     (bdqs_pkg::op_e'(opcode_i)),
    .value_i      (value_i),
    .head_i       (cell_data[0]),
    .busy_o       (busy_o),
    .chain_o      (chain),
    .done_o       (done_o),
    .found_o      (found_o),
    .status_o     (status),
    .held_count_o (held_count_o)
  );

  assign status_o = status;

  // Shift left advances toward the front and wraps the front cell to the last cell, so a
  // full rotation during search returns every entry to its place. Shift right opens
  // cell 0 for a push at the front.
  for (genvar i = 0; i < bdqs_pkg::Depth; i++) begin : g_cell
    localparam int unsigned Left  = (i + bdqs_pkg::Depth - 1) % bdqs_pkg::Depth;
    localparam int unsigned Right = (i + 1) % bdqs_pkg::Depth;

    bdqs_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (chain.cmd),
      .load_i  (chain.load_en && (chain.load_idx == bdqs_pkg::IdxW'(i))),
      .value_i (value_i),
      .left_i  (cell_data[Left]),
      .right_i (cell_data[Right]),
      .data_o  (cell_data[i])
    );
  end

endmodule
